// ===== rtl/fcrp_pkg.sv =====
// Shared types, constants and column lookup for the fixed-column record parser.
// Used by fixed_column_record_parser_top; depends on nothing else.
`timescale 1ns / 1ps

package fcrp_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned FieldCount = 7;
  localparam int unsigned FieldIdxW  = 3;
  localparam int unsigned ColW       = 5;
  localparam int unsigned MagW       = 17;
  localparam int unsigned WideW      = 18;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned OutDataW   = 88;

  localparam logic [ColW-1:0] KeptColumns = 5'd29;

  localparam logic [ByteW-1:0] ChNewline = 8'h0A;
  localparam logic [ByteW-1:0] ChReturn  = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChVtab    = 8'h0B;
  localparam logic [ByteW-1:0] ChFeed    = 8'h0C;
  localparam logic [ByteW-1:0] ChPlus    = 8'h2B;
  localparam logic [ByteW-1:0] ChMinus   = 8'h2D;
  localparam logic [ByteW-1:0] ChZero    = 8'h30;
  localparam logic [ByteW-1:0] ChNine    = 8'h39;

  // First column and one-past-last column of each field
  localparam logic [ColW-1:0] ColFirst [FieldCount] = '{5'd0, 5'd2, 5'd4, 5'd10,
                                                        5'd16, 5'd22, 5'd28};
  localparam logic [ColW-1:0] ColLimit [FieldCount] = '{5'd1, 5'd3, 5'd9, 5'd15,
                                                        5'd21, 5'd27, 5'd29};

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_e;

  typedef struct packed {
    logic                 hit;
    logic [FieldIdxW-1:0] idx;
  } field_sel_t;

  // Map a column position to the field that owns it, if any
  function automatic field_sel_t field_of_col(input logic [ColW-1:0] col);
    field_sel_t sel;
    sel = '0;
    for (int f = 0; f < FieldCount; f++) begin
      if (col >= ColFirst[f] && col < ColLimit[f]) begin
        sel.hit = 1'b1;
        sel.idx = FieldIdxW'(f);
      end
    end
    return sel;
  endfunction

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVtab) || (c == ChFeed);
  endfunction

endpackage

// ===== rtl/fixed_column_record_parser_top.sv =====
// Fixed-column record parser: decodes an ASCII record line byte by byte.
// Depends on fcrp_pkg for constants, the phase type and the column lookup.
`timescale 1ns / 1ps
//
//  channel   direction  tdata fields (low bit first)                      tuser/tlast
//  s_axis    in         rx_byte[7:0]                                      none
//  m_axis    out        7 decoded fields, 84 bits, zero-padded to 88      none
//
//  One byte per cycle sustained: a byte lands in an input register, then it
//  updates the owning field's decoder and, on newline, loads the result
//  register. Reset (rst_ni low, asynchronous) clears the column count, all
//  field decoders and both valid flags. A stalled result blocks only newline
//  bytes; other bytes keep flowing while a result waits to be taken.

module fixed_column_record_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [3:0] left_line_sensor, [7:4] right_line_sensor, [25:8] left_range_first,
  // [43:26] left_range_second, [61:44] right_range_first,
  // [79:62] right_range_second, [83:80] mode_digit, [87:84] zero
  output logic [87:0] m_axis_tdata_o
);

  localparam int unsigned N = fcrp_pkg::FieldCount;

  // Input register
  logic                         in_valid_q;
  logic [fcrp_pkg::ByteW-1:0]   in_byte_q;

  // Line state
  logic [fcrp_pkg::ColW-1:0]    col_q, col_d;
  logic [fcrp_pkg::MagW-1:0]    mag_q [N];
  logic [fcrp_pkg::MagW-1:0]    mag_d [N];
  fcrp_pkg::phase_e             phase_q [N];
  fcrp_pkg::phase_e             phase_d [N];
  logic                         neg_q [N];
  logic                         neg_d [N];

  // Result register
  logic                         out_valid_q;
  logic [fcrp_pkg::OutDataW-1:0] out_data_q, out_data_d;

  logic is_nl, is_cr, proc_go, take_col;
  fcrp_pkg::field_sel_t         sel;
  logic                         is_digit;
  logic [fcrp_pkg::MagW-1:0]    cur_mag, upd_mag;
  fcrp_pkg::phase_e             cur_phase, upd_phase;
  logic                         cur_neg, upd_neg;
  logic [fcrp_pkg::MagW+3:0]    mag_x10;
  logic [fcrp_pkg::WideW-1:0]   fval [N];

  assign is_nl = (in_byte_q == fcrp_pkg::ChNewline);
  assign is_cr = (in_byte_q == fcrp_pkg::ChReturn);

  // Newline needs a free result slot; everything else always retires
  assign proc_go  = in_valid_q && (!is_nl || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc_go;

  assign take_col = !is_nl && !is_cr && (col_q < fcrp_pkg::KeptColumns);
  assign sel      = fcrp_pkg::field_of_col(col_q);
  assign is_digit = (in_byte_q >= fcrp_pkg::ChZero) && (in_byte_q <= fcrp_pkg::ChNine);

  assign cur_mag   = mag_q[sel.idx];
  assign cur_phase = phase_q[sel.idx];
  assign cur_neg   = neg_q[sel.idx];
  assign mag_x10   = {1'b0, cur_mag, 3'b000} + {3'b000, cur_mag, 1'b0}
                   + {{(fcrp_pkg::MagW){1'b0}}, in_byte_q[3:0]};

  // Shared atol step for the field that owns the current column
  always_comb begin
    upd_mag   = cur_mag;
    upd_phase = cur_phase;
    upd_neg   = cur_neg;
    case (cur_phase)
      fcrp_pkg::PH_LEAD: begin
        if (fcrp_pkg::is_blank(in_byte_q)) begin
          upd_phase = fcrp_pkg::PH_LEAD;
        end else if (in_byte_q == fcrp_pkg::ChPlus) begin
          upd_phase = fcrp_pkg::PH_DIGITS;
        end else if (in_byte_q == fcrp_pkg::ChMinus) begin
          upd_phase = fcrp_pkg::PH_DIGITS;
          upd_neg   = 1'b1;
        end else if (is_digit) begin
          upd_phase = fcrp_pkg::PH_DIGITS;
          upd_mag   = {{(fcrp_pkg::MagW-4){1'b0}}, in_byte_q[3:0]};
        end else begin
          upd_phase = fcrp_pkg::PH_DONE;
        end
      end
      fcrp_pkg::PH_DIGITS: begin
        if (is_digit) begin
          upd_mag = mag_x10[fcrp_pkg::MagW-1:0];
        end else begin
          upd_phase = fcrp_pkg::PH_DONE;
        end
      end
      default: begin
        upd_phase = cur_phase;
      end
    endcase
  end

  always_comb begin
    col_d = col_q;
    for (int f = 0; f < N; f++) begin
      mag_d[f]   = mag_q[f];
      phase_d[f] = phase_q[f];
      neg_d[f]   = neg_q[f];
    end
    if (proc_go) begin
      if (is_nl) begin
        col_d = '0;
        for (int f = 0; f < N; f++) begin
          mag_d[f]   = '0;
          phase_d[f] = fcrp_pkg::PH_LEAD;
          neg_d[f]   = 1'b0;
        end
      end else if (take_col) begin
        col_d = col_q + fcrp_pkg::ColW'(1);
        for (int f = 0; f < N; f++) begin
          if (sel.hit && (sel.idx == fcrp_pkg::FieldIdxW'(f))) begin
            mag_d[f]   = upd_mag;
            phase_d[f] = upd_phase;
            neg_d[f]   = upd_neg;
          end
        end
      end
    end
  end

  // Apply sign, then pack the result fields
  always_comb begin
    for (int f = 0; f < N; f++) begin
      fval[f] = neg_q[f] ? (fcrp_pkg::WideW'(0) - {1'b0, mag_q[f]}) : {1'b0, mag_q[f]};
    end
    out_data_d = {4'b0000, fval[6][3:0], fval[5], fval[4], fval[3], fval[2],
                  fval[1][3:0], fval[0][3:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      for (int f = 0; f < N; f++) begin
        mag_q[f]   <= '0;
        phase_q[f] <= fcrp_pkg::PH_LEAD;
        neg_q[f]   <= 1'b0;
      end
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (proc_go && is_nl) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      col_q <= col_d;
      for (int f = 0; f < N; f++) begin
        mag_q[f]   <= mag_d[f];
        phase_q[f] <= phase_d[f];
        neg_q[f]   <= neg_d[f];
      end
    end
  end

  // Payload registers: hold unless a new transaction is loaded
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (proc_go && is_nl) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ===== sim/tb_fixed_column_record_parser_top.sv =====
// Self-checking testbench for fixed_column_record_parser_top: streams record bytes in and
// checks each decoded record against a line decoder kept in the bench.
// Depends on fcrp_pkg and the top-level RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_fixed_column_record_parser_top;

  localparam int unsigned RandomBytes = 640;
  localparam int unsigned MinLines    = 16;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned MaxReports  = 10;

  // Result layout, lowest field last
  typedef struct packed {
    logic [3:0]         pad;
    logic [3:0]         mode;
    logic signed [17:0] rr_second;
    logic signed [17:0] rr_first;
    logic signed [17:0] lr_second;
    logic signed [17:0] lr_first;
    logic [3:0]         right_line;
    logic [3:0]         left_line;
  } record_t;

  typedef struct {
    logic [7:0] b;
    bit         drain;
  } stim_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [7:0]                    in_byte = '0;
  logic                          rec_valid;
  logic                          rec_ready = 1'b0;
  logic [fcrp_pkg::OutDataW-1:0] rec_data;

  stim_t      byte_q[$];
  record_t    record_q[$];
  logic [7:0] line_buf[$];
  bit         drain_next;

  // Line decoder state
  logic [fcrp_pkg::ColW-1:0] col_pos;
  logic [fcrp_pkg::MagW-1:0] mag [fcrp_pkg::FieldCount];
  fcrp_pkg::phase_e          phase [fcrp_pkg::FieldCount];
  logic                      neg [fcrp_pkg::FieldCount];

  int unsigned in_gap;
  int unsigned rec_stall;
  int unsigned stall_now;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned bytes_taken;
  int unsigned records_seen;
  int unsigned mismatches;
  int unsigned stuck_cycles;

  always #10 clk_i = ~clk_i;

  fixed_column_record_parser_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_byte),
    .m_axis_tvalid_o (rec_valid),
    .m_axis_tready_i (rec_ready),
    .m_axis_tdata_o  (rec_data)
  );

  function automatic void clear_line();
    col_pos = '0;
    for (int f = 0; f < fcrp_pkg::FieldCount; f++) begin
      mag[f]   = '0;
      phase[f] = fcrp_pkg::PH_LEAD;
      neg[f]   = 1'b0;
    end
  endfunction

  // Advance the line decoder by one accepted byte; queue a record on newline
  function automatic void take_byte(input logic [7:0] c);
    record_t     rec;
    logic [17:0] val [fcrp_pkg::FieldCount];
    logic        digit;
    if (c == fcrp_pkg::ChNewline) begin
      for (int f = 0; f < fcrp_pkg::FieldCount; f++)
        val[f] = neg[f] ? 18'(-{1'b0, mag[f]}) : {1'b0, mag[f]};
      rec            = '0;
      rec.left_line  = val[0][3:0];
      rec.right_line = val[1][3:0];
      rec.lr_first   = val[2];
      rec.lr_second  = val[3];
      rec.rr_first   = val[4];
      rec.rr_second  = val[5];
      rec.mode       = val[6][3:0];
      record_q.push_back(rec);
      clear_line();
    end else if (c != fcrp_pkg::ChReturn && col_pos < fcrp_pkg::KeptColumns) begin
      digit = (c >= fcrp_pkg::ChZero) && (c <= fcrp_pkg::ChNine);
      for (int f = 0; f < fcrp_pkg::FieldCount; f++) begin
        if (col_pos >= fcrp_pkg::ColFirst[f] && col_pos < fcrp_pkg::ColLimit[f]) begin
          case (phase[f])
            fcrp_pkg::PH_LEAD: begin
              if (c == fcrp_pkg::ChSpace || c == fcrp_pkg::ChTab ||
                  c == fcrp_pkg::ChVtab || c == fcrp_pkg::ChFeed) begin
                // skip leading whitespace
              end else if (c == fcrp_pkg::ChPlus) begin
                phase[f] = fcrp_pkg::PH_DIGITS;
              end else if (c == fcrp_pkg::ChMinus) begin
                phase[f] = fcrp_pkg::PH_DIGITS;
                neg[f]   = 1'b1;
              end else if (digit) begin
                phase[f] = fcrp_pkg::PH_DIGITS;
                mag[f]   = fcrp_pkg::MagW'(c - fcrp_pkg::ChZero);
              end else begin
                phase[f] = fcrp_pkg::PH_DONE;
              end
            end
            fcrp_pkg::PH_DIGITS: begin
              if (digit) mag[f] = fcrp_pkg::MagW'(mag[f] * 10 + (c - fcrp_pkg::ChZero));
              else phase[f] = fcrp_pkg::PH_DONE;
            end
            default: ;
          endcase
        end
      end
      col_pos = col_pos + 1'b1;
    end
  endfunction

  function automatic string show(input record_t r);
    return $sformatf("%0d %0d %0d %0d %0d %0d %0d pad=%0h", r.left_line, r.right_line,
                     r.lr_first, r.lr_second, r.rr_first, r.rr_second, r.mode, r.pad);
  endfunction

  function automatic void check_record(input record_t got);
    record_t want;
    bit      bad;
    if (record_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("unexpected record at %0t: %s", $realtime, show(got));
      return;
    end
    want = record_q.pop_front();
    bad  = (got.left_line !== want.left_line) || (got.right_line !== want.right_line) ||
           (got.lr_first !== want.lr_first) || (got.lr_second !== want.lr_second) ||
           (got.rr_first !== want.rr_first) || (got.rr_second !== want.rr_second) ||
           (got.mode !== want.mode) || (got.pad !== want.pad);
    if (bad) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("record %0d mismatch: expected %s, got %s",
                 records_seen, show(want), show(got));
    end
  endfunction

  function automatic int unsigned idle_draw(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == fcrp_pkg::ChNewline);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 3))
      0: return fcrp_pkg::ChSpace;
      1: return fcrp_pkg::ChTab;
      2: return fcrp_pkg::ChVtab;
      default: return fcrp_pkg::ChFeed;
    endcase
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    byte_q.push_back('{b: b, drain: drain_next});
    drain_next = 1'b0;
  endfunction

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  // Mostly well-formed lines with random content; some noise, long and short lines
  task automatic gen_line();
    int unsigned kind;
    int unsigned room;
    int unsigned nb;
    int unsigned nd;
    kind = $urandom_range(0, 9);
    line_buf.delete();
    if (kind == 0) begin
      repeat ($urandom_range(0, 40)) line_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int f = 0; f < fcrp_pkg::FieldCount; f++) begin
        if (f != 0) begin
          line_buf.push_back(($urandom_range(0, 4) == 0) ? text_byte()
                                                         : fcrp_pkg::ChSpace);
        end
        if (fcrp_pkg::ColLimit[f] - fcrp_pkg::ColFirst[f] == 1) begin
          line_buf.push_back(($urandom_range(0, 4) == 0) ? text_byte()
                             : 8'(fcrp_pkg::ChZero + $urandom_range(0, 9)));
        end else begin
          room = 5;
          nb   = $urandom_range(0, 2);
          repeat (nb) line_buf.push_back(blank_byte());
          room -= nb;
          case ($urandom_range(0, 3))
            2: begin
              line_buf.push_back(fcrp_pkg::ChPlus);
              room--;
            end
            3: begin
              line_buf.push_back(fcrp_pkg::ChMinus);
              room--;
            end
            default: ;
          endcase
          nd = ($urandom_range(0, 2) == 0) ? $urandom_range(0, room) : room;
          repeat (nd) line_buf.push_back(8'(fcrp_pkg::ChZero + $urandom_range(0, 9)));
          room -= nd;
          repeat (room) begin
            line_buf.push_back($urandom_range(0, 1) ? fcrp_pkg::ChSpace : text_byte());
          end
        end
      end
      if (kind == 1) begin
        repeat ($urandom_range(1, 12)) line_buf.push_back(text_byte());
      end else if (kind == 2) begin
        nb = $urandom_range(0, 28);
        while (line_buf.size() > nb) void'(line_buf.pop_back());
      end
    end
    foreach (line_buf[i]) begin
      if ($urandom_range(0, 19) == 0) add_byte(fcrp_pkg::ChReturn);
      add_byte(line_buf[i]);
    end
    add_byte(fcrp_pkg::ChNewline);
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_byte  <= '0;
      in_gap   <= 0;
    end else begin
      if (in_valid && in_ready) begin
        take_byte(in_byte);
        bytes_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap   <= in_gap - 1;
        end else if (byte_q.size() != 0 && !(byte_q[0].drain && record_q.size() != 0)) begin
          in_valid <= 1'b1;
          in_byte  <= byte_q[0].b;
          byte_q.delete(0);
          in_gap   <= idle_draw((bytes_taken / 120) % 3 == 2);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_ready <= 1'b0;
      rec_stall <= 0;
    end else begin
      if (rec_valid && rec_ready) begin
        check_record(record_t'(rec_data));
        records_seen++;
        stall_now = idle_draw((records_seen / 6) % 3 == 2);
      end else begin
        stall_now = rec_stall;
      end
      if (stall_now != 0) begin
        rec_ready <= 1'b0;
        rec_stall <= stall_now - 1;
      end else begin
        rec_ready <= (hold_left == 0);
        rec_stall <= 0;
      end
    end
  end

  // Long receiver hold-off while the sender keeps going
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && records_seen >= 10) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (rec_valid && rec_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    wait (stuck_cycles >= StuckLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned directed_n;
    int unsigned lines;
    clear_line();
    // extremes
    add_text("9 9 99999 99999 99999 99999 9\n");
    add_text("0 0 -9999 +0000   -      +7 -\n");
    // whitespace kinds, carriage return, zero byte, letters stop a field
    add_text("5 ");
    add_byte(fcrp_pkg::ChReturn);
    add_text("3 ");
    add_byte(fcrp_pkg::ChTab);
    add_byte(fcrp_pkg::ChVtab);
    add_byte(fcrp_pkg::ChFeed);
    add_text("-1 4");
    add_byte(8'h00);
    add_text("77 x1234");
    add_byte(8'hFF);
    add_text("12a34 a\n");
    // empty, short and long lines
    add_text("\n");
    add_text("7 3 123\n");
    add_text("1 2 00001 00002 00003 00004 5678901234567890");
    add_byte(8'h80);
    add_text("\n");
    directed_n = byte_q.size();
    // hold the stream until the directed records have all come back
    drain_next = 1'b1;
    lines = 0;
    while (byte_q.size() - directed_n < RandomBytes || lines < MinLines) begin
      gen_line();
      lines++;
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid || record_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fcrp_pkg.sv
rtl/fixed_column_record_parser_top.sv
sim/tb_fixed_column_record_parser_top.sv
